// ----- design/msort_pkg.sv -----
`default_nettype none

package msort_pkg;

  // one word on the input channel
  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } msort_in_t;

  // one word on the result channel
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_result;
    logic               overflow;
  } msort_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_POP,
    ST_CPY,
    ST_CDRAIN,
    ST_PRIME,
    ST_MRG,
    ST_OUT_RD,
    ST_OUT
  } msort_state_t;

  // frame phase codes
  localparam logic [1:0] PH_SPLIT_LO = 2'd0;
  localparam logic [1:0] PH_SPLIT_HI = 2'd1;
  localparam logic [1:0] PH_MERGE    = 2'd2;

endpackage

`default_nettype wire

// ----- design/msort_ifs.sv -----
`default_nettype none

interface msort_in_if;
  import msort_pkg::*;
  logic      valid;
  logic      ready;
  msort_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msort_out_if;
  import msort_pkg::*;
  logic       valid;
  logic       ready;
  msort_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/merge_sorter.sv -----
// merge_sorter: collects a set of signed 32-bit words and returns them sorted
// in_ch  : valid/ready word channel, value plus last_item; accepted on valid & ready
// out_ch : valid/ready word channel, sorted_value, last_result, overflow
// loading accepts one word a cycle; ready is low from the last word of a set
//   until the final sorted word of that set has been taken
// words beyond CAPACITY are dropped, and overflow is raised on every result
//   of that set; the word carrying last_item always starts the sort
// sorting is a stable top-down merge sort run from a frame stack; each merge
//   copies its range from the element store into the merge buffer (one word a
//   cycle) and writes the merged run back (one word a cycle), and each frame
//   is popped in a state of its own (ST_POP)
// after the last sort step the first result is read from the store in ST_OUT_RD
//   and shown in ST_OUT, then one word a cycle while the receiver takes them
// a receiver stall simply holds the current result word; nothing is lost
// reset (rst_n low, synchronous) empties the set and the frame stack; the
//   memories hold no reset value and need no clearing pass
`default_nettype none

module merge_sorter #(
  parameter int CAPACITY    = 64,
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  msort_in_if.sink         in_ch,
  msort_out_if.source      out_ch
);
  import msort_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int SIX_W = $clog2(STACK_DEPTH);

  // state machine
  msort_state_t state_r, state_nxt;

  // batch bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;

  // frame stack, held in flops: one pop address, up to two pushes a cycle
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [IDX_W-1:0] frm_lo_r [STACK_DEPTH];
  logic [IDX_W-1:0] frm_hi_r [STACK_DEPTH];
  logic [1:0]       frm_ph_r [STACK_DEPTH];

  logic             push_a_en, push_b_en;
  logic [SIX_W-1:0] push_a_idx, push_b_idx;
  logic [IDX_W-1:0] push_a_lo, push_a_hi, push_b_lo, push_b_hi;
  logic [1:0]       push_a_ph, push_b_ph;

  // current merge range
  logic [IDX_W-1:0] m_lo_r, m_mid_r, m_hi_r;
  logic [IDX_W-1:0] m_lo_nxt, m_mid_nxt, m_hi_nxt;

  // copy pointer and delayed buffer write
  logic [IDX_W-1:0] cp_r, cp_nxt;
  logic             bw_vld_r, bw_vld_nxt;
  logic [IDX_W-1:0] bw_addr_r, bw_addr_nxt;

  // merge pointers; i and j may run one past their run
  logic [IDX_W:0]   i_r, j_r, i_nxt, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  // output index
  logic [IDX_W-1:0] ok_r, ok_nxt;

  // element store: one write port, one read port
  logic signed [31:0] store_mem [CAPACITY];
  logic               st_we, st_re;
  logic [IDX_W-1:0]   st_wa, st_ra;
  logic signed [31:0] st_wd;
  logic signed [31:0] st_q_r;

  // merge buffer: one write port, two read ports
  logic signed [31:0] mbuf_mem [CAPACITY];
  logic               b_re;
  logic [IDX_W-1:0]   b_ra0, b_ra1;
  logic signed [31:0] bq_a_r, bq_b_r;

  // handshake
  logic in_rdy, in_acc, out_vld, out_acc, out_last;

  // frame decode
  logic [SP_W-1:0]  sp_dec;
  logic [SIX_W-1:0] top_idx;
  logic [IDX_W-1:0] f_lo, f_hi, f_mid, f_mid1;
  logic [1:0]       f_ph;
  logic [IDX_W:0]   f_sum;
  logic             stack_room, f_split, f_merge;

  // load decode
  logic             has_room;
  logic [CNT_W-1:0] n_after;

  // merge decode
  logic i_done, j_done, take_a;

  assign in_acc   = in_ch.valid && in_rdy;
  assign out_acc  = out_vld && out_ch.ready;
  assign out_last = ((CNT_W'(ok_r) + CNT_W'(1)) == count_r);

  assign has_room = (count_r < CNT_W'(CAPACITY));
  assign n_after  = has_room ? (count_r + CNT_W'(1)) : count_r;

  assign sp_dec     = sp_r - SP_W'(1);
  assign top_idx    = sp_dec[SIX_W-1:0];
  assign f_lo       = frm_lo_r[top_idx];
  assign f_hi       = frm_hi_r[top_idx];
  assign f_ph       = frm_ph_r[top_idx];
  assign f_sum      = {1'b0, f_lo} + {1'b0, f_hi};
  assign f_mid      = f_sum[IDX_W:1];
  assign f_mid1     = f_mid + IDX_W'(1);
  assign stack_room = (sp_r < SP_W'(STACK_DEPTH));
  // a frame with an empty or single-word range is just discarded
  assign f_split    = (f_lo < f_hi) && ((f_ph == PH_SPLIT_LO) || (f_ph == PH_SPLIT_HI));
  assign f_merge    = (f_lo < f_hi) && (f_ph != PH_SPLIT_LO) && (f_ph != PH_SPLIT_HI);

  // left run wins ties, which keeps the sort stable
  assign i_done = (i_r > {1'b0, m_mid_r});
  assign j_done = (j_r > {1'b0, m_hi_r});
  assign take_a = j_done || (!i_done && (bq_a_r <= bq_b_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.data.last_item) begin
          state_nxt = (n_after < CNT_W'(2)) ? ST_OUT_RD : ST_POP;
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          state_nxt = ST_OUT_RD;
        end else if (f_merge) begin
          state_nxt = ST_CPY;
        end
      end
      ST_CPY: begin
        if (cp_r == m_hi_r) begin
          state_nxt = ST_CDRAIN;
        end
      end
      ST_CDRAIN: state_nxt = ST_PRIME;
      ST_PRIME:  state_nxt = ST_MRG;
      ST_MRG: begin
        if (k_r == m_hi_r) begin
          state_nxt = ST_POP;
        end
      end
      ST_OUT_RD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc && out_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    sp_nxt      = sp_r;
    push_a_en   = 1'b0;
    push_a_idx  = top_idx;
    push_a_lo   = f_lo;
    push_a_hi   = f_hi;
    push_a_ph   = PH_SPLIT_LO;
    push_b_en   = 1'b0;
    push_b_idx  = sp_r[SIX_W-1:0];
    push_b_lo   = f_lo;
    push_b_hi   = f_mid;
    push_b_ph   = PH_SPLIT_LO;
    m_lo_nxt    = m_lo_r;
    m_mid_nxt   = m_mid_r;
    m_hi_nxt    = m_hi_r;
    cp_nxt      = cp_r;
    bw_vld_nxt  = 1'b0;
    bw_addr_nxt = cp_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    ok_nxt      = ok_r;
    st_we       = 1'b0;
    st_wa       = k_r;
    st_wd       = in_ch.data.value;
    st_re       = 1'b0;
    st_ra       = cp_r;
    b_re        = 1'b0;
    b_ra0       = i_r[IDX_W-1:0];
    b_ra1       = j_r[IDX_W-1:0];
    in_rdy      = 1'b0;
    out_vld     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_rdy = 1'b1;
        if (in_acc) begin
          if (has_room) begin
            st_we     = 1'b1;
            st_wa     = count_r[IDX_W-1:0];
            count_nxt = n_after;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_ch.data.last_item && (n_after >= CNT_W'(2))) begin
            // root frame covers the whole set
            push_a_en  = 1'b1;
            push_a_idx = '0;
            push_a_lo  = '0;
            push_a_hi  = IDX_W'(n_after - CNT_W'(1));
            push_a_ph  = PH_SPLIT_LO;
            sp_nxt     = SP_W'(1);
          end
        end
      end
      ST_POP: begin
        if (sp_r != '0) begin
          sp_nxt = sp_dec;
          if (f_split) begin
            // continuation frame reuses the popped slot
            push_a_en = 1'b1;
            push_a_ph = (f_ph == PH_SPLIT_LO) ? PH_SPLIT_HI : PH_MERGE;
            sp_nxt    = sp_r;
            if (f_ph == PH_SPLIT_HI) begin
              push_b_lo = f_mid1;
              push_b_hi = f_hi;
            end
            // child frame dropped when the stack is full
            if (stack_room) begin
              push_b_en = 1'b1;
              sp_nxt    = sp_r + SP_W'(1);
            end
          end else if (f_merge) begin
            m_lo_nxt  = f_lo;
            m_mid_nxt = f_mid;
            m_hi_nxt  = f_hi;
            cp_nxt    = f_lo;
          end
        end
      end
      ST_CPY: begin
        st_re       = 1'b1;
        st_ra       = cp_r;
        bw_vld_nxt  = 1'b1;
        bw_addr_nxt = cp_r;
        cp_nxt      = cp_r + IDX_W'(1);
      end
      ST_CDRAIN: begin
        // last buffer write lands at the end of this cycle
      end
      ST_PRIME: begin
        b_re  = 1'b1;
        b_ra0 = m_lo_r;
        b_ra1 = m_mid_r + IDX_W'(1);
        i_nxt = {1'b0, m_lo_r};
        j_nxt = {1'b0, m_mid_r} + (IDX_W + 1)'(1);
        k_nxt = m_lo_r;
      end
      ST_MRG: begin
        st_we = 1'b1;
        st_wa = k_r;
        st_wd = take_a ? bq_a_r : bq_b_r;
        if (take_a) begin
          i_nxt = i_r + (IDX_W + 1)'(1);
        end else begin
          j_nxt = j_r + (IDX_W + 1)'(1);
        end
        k_nxt = k_r + IDX_W'(1);
        // fetch the heads for the next step
        b_re  = 1'b1;
        b_ra0 = i_nxt[IDX_W-1:0];
        b_ra1 = j_nxt[IDX_W-1:0];
      end
      ST_OUT_RD: begin
        st_re = 1'b1;
        st_ra = ok_r;
      end
      ST_OUT: begin
        out_vld = 1'b1;
        if (out_acc) begin
          if (out_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            ok_nxt      = '0;
          end else begin
            ok_nxt = ok_r + IDX_W'(1);
            st_re  = 1'b1;
            st_ra  = ok_r + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      sp_r      <= '0;
      bw_vld_r  <= 1'b0;
      ok_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      sp_r      <= sp_nxt;
      bw_vld_r  <= bw_vld_nxt;
      ok_r      <= ok_nxt;
    end
  end

  // payload registers and frame stack contents
  always_ff @(posedge clk) begin
    m_lo_r    <= m_lo_nxt;
    m_mid_r   <= m_mid_nxt;
    m_hi_r    <= m_hi_nxt;
    cp_r      <= cp_nxt;
    bw_addr_r <= bw_addr_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    if (push_a_en) begin
      frm_lo_r[push_a_idx] <= push_a_lo;
      frm_hi_r[push_a_idx] <= push_a_hi;
      frm_ph_r[push_a_idx] <= push_a_ph;
    end
    if (push_b_en) begin
      frm_lo_r[push_b_idx] <= push_b_lo;
      frm_hi_r[push_b_idx] <= push_b_hi;
      frm_ph_r[push_b_idx] <= push_b_ph;
    end
  end

  // element store
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_q_r <= store_mem[st_ra];
    end
  end

  // merge buffer, filled from the store read data in the cycle after the read
  always_ff @(posedge clk) begin
    if (bw_vld_r) begin
      mbuf_mem[bw_addr_r] <= st_q_r;
    end
    if (b_re) begin
      bq_a_r <= mbuf_mem[b_ra0];
      bq_b_r <= mbuf_mem[b_ra1];
    end
  end

  assign in_ch.ready              = in_rdy;
  assign out_ch.valid             = out_vld;
  assign out_ch.data.sorted_value = st_q_r;
  assign out_ch.data.last_result  = out_last;
  assign out_ch.data.overflow     = dropped_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("frame stack pointer beyond depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_bw_src: assert property (@(posedge clk) disable iff (!rst_n)
    bw_vld_r |-> (state_r == ST_CPY || state_r == ST_CDRAIN))
    else $error("merge buffer written outside a copy");

  a_mrg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MRG) |-> (k_r >= m_lo_r && k_r <= m_hi_r))
    else $error("merge write outside its range");

  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (count_r != '0))
    else $error("result shown for an empty set");

  a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> (state_r == ST_LOAD && count_r == '0 && !dropped_r))
    else $error("set state not cleared after final result");
`endif

endmodule

`default_nettype wire
